// File: rtl/core/sapf_pkg.sv
// Shared types, constants and register indexes for the servo angle frame parser.
package sapf_pkg;

  localparam int NUM_SERVOS_DEF = 32;

  localparam int CFG_IDX_W = 8;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_HEADER_BYTE   = cfg_idx_t'(0);
  localparam cfg_idx_t REG_ANGLE_COMMAND = cfg_idx_t'(1);

  localparam logic [7:0] HEADER_BYTE_RST   = 8'd85;
  localparam logic [7:0] ANGLE_COMMAND_RST = 8'd21;

  localparam int POS_W = 9;
  typedef logic [POS_W-1:0] pos_t;
  localparam pos_t POS_HDR0 = pos_t'(0);
  localparam pos_t POS_HDR1 = pos_t'(1);
  localparam pos_t POS_LEN  = pos_t'(2);
  localparam pos_t POS_CMD  = pos_t'(3);
  localparam pos_t POS_SKIP = pos_t'(4);
  localparam pos_t POS_MAX  = pos_t'(511);
  localparam pos_t LEN_ADJ  = pos_t'(2);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [4:0]  servo_slot;
    logic [15:0] angle_value;
  } out_t;

  typedef struct packed {
    logic vld;
    out_t item;
  } res_t;

  typedef enum logic [2:0] {
    PH_ID   = 3'b001,
    PH_LOW  = 3'b010,
    PH_HIGH = 3'b100
  } phase_t;

endpackage

// File: rtl/core/servo_angle_frame_parser.sv
// Servo angle frame parser top level: configuration registers, frame tracker, result queue.
// Takes one frame byte per clock; with the result side free, an angle update appears on
// the result port the cycle after the last byte of its triple. The input is stalled only
// while both the result register and the skid stage behind it hold undelivered updates,
// so with a free result side it sustains one byte every cycle. Config writes are always ready.
module servo_angle_frame_parser
  import sapf_pkg::*;
#(
  parameter int NUM_SERVOS = NUM_SERVOS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_idx_t   cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] header_byte_r, header_byte_nxt;
  logic [7:0] angle_command_r, angle_command_nxt;
  logic       acc;
  logic       skid_full;
  res_t       res;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_full;
  assign acc       = in_valid && !in_stall;

  always_comb begin
    header_byte_nxt   = header_byte_r;
    angle_command_nxt = angle_command_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEADER_BYTE:   header_byte_nxt   = cfg_data;
        REG_ANGLE_COMMAND: angle_command_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_byte_r   <= HEADER_BYTE_RST;
      angle_command_r <= ANGLE_COMMAND_RST;
    end else begin
      header_byte_r   <= header_byte_nxt;
      angle_command_r <= angle_command_nxt;
    end
  end

  sapf_parse #(
    .NUM_SERVOS(NUM_SERVOS)
  ) u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .in_data      (in_data),
    .header_byte  (header_byte_r),
    .angle_command(angle_command_r),
    .res          (res)
  );

  sapf_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .skid_full(skid_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// File: rtl/core/sapf_parse.sv
// Frame tracker: byte position, header/command checks and triple assembly.
module sapf_parse
  import sapf_pkg::*;
#(
  parameter int NUM_SERVOS = NUM_SERVOS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  in_t        in_data,
  input  logic [7:0] header_byte,
  input  logic [7:0] angle_command,
  output res_t       res
);

  localparam logic [7:0] ID_MAX = 8'(NUM_SERVOS);

  pos_t       byte_position_r, byte_position_nxt;
  logic       header_good_r, header_good_nxt;
  pos_t       total_length_r, total_length_nxt;
  logic       command_match_r, command_match_nxt;
  phase_t     phase_r, phase_nxt;
  logic [7:0] held_id_r, held_id_nxt;
  logic [7:0] held_low_r, held_low_nxt;
  logic       in_range_r, in_range_nxt;

  pos_t       pos_cur;
  logic [7:0] b;
  logic [7:0] id_m1;

  assign b       = in_data.data_byte;
  assign pos_cur = in_data.frame_start ? POS_HDR0 : byte_position_r;
  assign id_m1   = held_id_r - 8'd1;

  always_comb begin
    byte_position_nxt = byte_position_r;
    header_good_nxt   = header_good_r;
    total_length_nxt  = total_length_r;
    command_match_nxt = command_match_r;
    phase_nxt         = phase_r;
    held_id_nxt       = held_id_r;
    held_low_nxt      = held_low_r;
    in_range_nxt      = in_range_r;
    res.vld           = 1'b0;
    res.item.servo_slot  = id_m1[4:0];
    res.item.angle_value = {b, held_low_r};
    if (acc) begin
      byte_position_nxt = (pos_cur < POS_MAX) ? pos_cur + pos_t'(1) : POS_MAX;
      case (pos_cur)
        POS_HDR0: begin
          header_good_nxt   = (b == header_byte);
          total_length_nxt  = '0;
          command_match_nxt = 1'b0;
          phase_nxt         = PH_ID;
          in_range_nxt      = 1'b0;
        end
        POS_HDR1: header_good_nxt = header_good_r && (b == header_byte);
        POS_LEN:  total_length_nxt = pos_t'(b) + LEN_ADJ;
        POS_CMD:  command_match_nxt = (b == angle_command);
        POS_SKIP: phase_nxt = PH_ID;
        default: begin
          case (phase_r)
            PH_LOW: begin
              held_low_nxt = b;
              phase_nxt    = PH_HIGH;
            end
            PH_HIGH: begin
              phase_nxt = PH_ID;
              res.vld   = header_good_r && command_match_r && in_range_r &&
                          (held_id_r != 8'd0) && (held_id_r <= ID_MAX);
            end
            default: begin
              held_id_nxt  = b;
              in_range_nxt = (pos_cur < total_length_r);
              phase_nxt    = PH_LOW;
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r <= '0;
      header_good_r   <= 1'b0;
      total_length_r  <= '0;
      command_match_r <= 1'b0;
      phase_r         <= PH_ID;
      in_range_r      <= 1'b0;
    end else begin
      byte_position_r <= byte_position_nxt;
      header_good_r   <= header_good_nxt;
      total_length_r  <= total_length_nxt;
      command_match_r <= command_match_nxt;
      phase_r         <= phase_nxt;
      in_range_r      <= in_range_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_id_r  <= held_id_nxt;
    held_low_r <= held_low_nxt;
  end

endmodule

// File: rtl/core/sapf_outq.sv
// Result register with a skid stage so the input keeps flowing under output stall.
module sapf_outq
  import sapf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  res_t res,
  output logic skid_full,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;
  logic skid_valid_r, skid_valid_nxt;
  out_t skid_data_r, skid_data_nxt;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = res.vld;
        skid_data_nxt  = res.item;
      end else begin
        out_valid_nxt = res.vld;
        out_data_nxt  = res.item;
      end
    end else if (res.vld) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign skid_full = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/sapf_chk.sv
// Port-level checker for the servo angle frame parser, bound to the top level.
module sapf_chk
  import sapf_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("outputs not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_no_spont: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && !in_stall) |=> !out_valid)
    else $error("result without a transfer");

  a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_valid && !in_stall && in_data.frame_start |=> !out_valid)
    else $error("frame start byte produced a result");

endmodule

bind servo_angle_frame_parser sapf_chk u_sapf_chk (.*);
